[design/segment_display_serial_driver_core_defines.svh]
// Assertion macros shared by the segment display serial driver RTL.
// Every macro samples on i_clk and is disabled while i_rst_n is low.
`ifndef SEGMENT_DISPLAY_SERIAL_DRIVER_CORE_DEFINES_SVH
`define SEGMENT_DISPLAY_SERIAL_DRIVER_CORE_DEFINES_SVH

// Property that must hold at every clock edge outside reset.
`define SDD_ASSERT(label, prop, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (prop)) \
        else $error(msg);

// When cond holds, conseq must hold in the next cycle.
`define SDD_ASSERT_NEXT(label, cond, conseq, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (cond) |=> (conseq)) \
        else $error(msg);

`endif

[design/sdd_pkg.sv]
// Types, constants and segment tables of the segment display serial driver.
// No dependencies; every other design file except the assertion macro header uses this package.
package sdd_pkg;

    localparam int PAT_W = 16;
    localparam int CNT_W = 4;
    localparam logic [CNT_W-1:0] BIT_LAST = 4'd15;
    localparam logic [7:0] NUM_MAX = 8'd129;
    localparam logic [7:0] NUM_TENS_MIN = 8'd10;
    // Reciprocal of ten as 205 / 2048, exact for every value up to 129.
    localparam logic [15:0] DIV10_MUL = 16'd205;
    localparam int DIV10_SHIFT = 11;

    typedef enum logic {
        OP_NUMBER = 1'b0,
        OP_LETTER = 1'b1
    } t_op;

    typedef struct packed {
        logic       operation;
        logic [7:0] value;
        logic       display_enable;
    } t_in_item;

    typedef struct packed {
        logic serial_data;
        logic strobe_last;
        logic panel_on;
    } t_out_item;

    typedef struct packed {
        logic [PAT_W-1:0] pattern;
        logic             display_enable;
    } t_pat_item;

    // Segment pattern of the tens digit (and the hundreds marks).
    function automatic logic [PAT_W-1:0] tens_seg(input logic [3:0] idx);
        logic [PAT_W-1:0] seg;
        unique case (idx)
            4'd0:    seg = 16'h2A2C;
            4'd1:    seg = 16'h2020;
            4'd2:    seg = 16'h280D;
            4'd3:    seg = 16'h2829;
            4'd4:    seg = 16'h2221;
            4'd5:    seg = 16'h0A29;
            4'd6:    seg = 16'h0A2D;
            4'd7:    seg = 16'h2820;
            4'd8:    seg = 16'h2A2D;
            4'd9:    seg = 16'h2A29;
            4'd10:   seg = 16'h4000;
            4'd11:   seg = 16'h1000;
            4'd12:   seg = 16'h0001;
            default: seg = '0;
        endcase
        return seg;
    endfunction

    // Segment pattern of the ones digit.
    function automatic logic [PAT_W-1:0] ones_seg(input logic [3:0] idx);
        logic [PAT_W-1:0] seg;
        unique case (idx)
            4'd0:    seg = 16'h94D0;
            4'd1:    seg = 16'h0480;
            4'd2:    seg = 16'h90C2;
            4'd3:    seg = 16'h14C2;
            4'd4:    seg = 16'h0492;
            4'd5:    seg = 16'h1452;
            4'd6:    seg = 16'h9452;
            4'd7:    seg = 16'h04C0;
            4'd8:    seg = 16'h94D2;
            4'd9:    seg = 16'h14D2;
            default: seg = '0;
        endcase
        return seg;
    endfunction

    // Letter pattern: upper table entry plus lower table entry, 16-bit wrap.
    function automatic logic [PAT_W-1:0] letter_seg(input logic [2:0] idx);
        logic [PAT_W-1:0] hi;
        logic [PAT_W-1:0] lo;
        unique case (idx)
            3'd0: hi = 16'h0000;
            3'd1: hi = 16'h2A25;
            3'd2: hi = 16'h222C;
            3'd3: hi = 16'h2820;
            3'd4: hi = 16'h2A2C;
            3'd5: hi = 16'h2A24;
            3'd6: hi = 16'h2A25;
            3'd7: hi = 16'h2A24;
        endcase
        unique case (idx)
            3'd3:    lo = 16'h0040;
            3'd5:    lo = 16'h04C0;
            default: lo = 16'h0000;
        endcase
        return hi + lo;
    endfunction

endpackage

[design/sdd_if.sv]
// Valid/ready stream interfaces for the input and result channels.
// Depends on sdd_pkg for the payload structs.
interface sdd_in_if;
    logic              valid;
    logic              ready;
    sdd_pkg::t_in_item payload;

    modport source (output valid, output payload, input ready);
    modport sink (input valid, input payload, output ready);
endinterface

interface sdd_out_if;
    logic               valid;
    logic               ready;
    sdd_pkg::t_out_item payload;

    modport source (output valid, output payload, input ready);
    modport sink (input valid, input payload, output ready);
endinterface

[design/sdd_encode.sv]
// Input register and segment pattern register of the display driver.
// Depends on sdd_pkg and sdd_in_if.
module sdd_encode (
    input  logic              i_clk,
    input  logic              i_rst_n,
    sdd_in_if.sink            i_in,
    output sdd_pkg::t_pat_item o_pat,
    output logic              o_pat_valid,
    input  logic              i_pat_ready
);
    import sdd_pkg::*;

    logic             r_in_valid;
    t_in_item         r_in;
    logic             r_pat_valid;
    t_pat_item        r_pat;

    logic             in_xfer;
    logic             s1_take;
    logic [7:0]       sat;
    logic [15:0]      prod;
    logic [3:0]       tens;
    logic [7:0]       rem_full;
    logic [3:0]       ones;
    logic [PAT_W-1:0] n_pattern;

    assign s1_take    = r_in_valid && (!r_pat_valid || i_pat_ready);
    assign i_in.ready = !r_in_valid || s1_take;
    assign in_xfer    = i_in.valid && i_in.ready;

    // Saturate, then split into digits with a reciprocal multiply.
    assign sat      = (r_in.value > NUM_MAX) ? NUM_MAX : r_in.value;
    assign prod     = {8'd0, sat} * DIV10_MUL;
    assign tens     = prod[DIV10_SHIFT +: 4];
    assign rem_full = sat - 8'(8'(tens) * 8'd10);
    assign ones     = rem_full[3:0];

    always_comb begin
        if (t_op'(r_in.operation) == OP_LETTER) begin
            n_pattern = letter_seg(r_in.value[2:0]);
        end else if (sat < NUM_TENS_MIN) begin
            n_pattern = ones_seg(ones);
        end else begin
            n_pattern = tens_seg(tens) + ones_seg(ones);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid  <= 1'b0;
            r_pat_valid <= 1'b0;
        end else begin
            r_in_valid <= in_xfer || (r_in_valid && !s1_take);
            if (s1_take) begin
                r_pat_valid <= 1'b1;
            end else if (i_pat_ready) begin
                r_pat_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_xfer) begin
            r_in <= i_in.payload;
        end
        if (s1_take) begin
            r_pat.pattern        <= n_pattern;
            r_pat.display_enable <= r_in.display_enable;
        end
    end

    assign o_pat       = r_pat;
    assign o_pat_valid = r_pat_valid;

endmodule

[design/sdd_serializer.sv]
// Sixteen-bit shift-out stage with a registered result channel.
// Depends on sdd_pkg, sdd_out_if and the project assertion macros.
`include "segment_display_serial_driver_core_defines.svh"

module sdd_serializer (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  sdd_pkg::t_pat_item i_pat,
    input  logic               i_pat_valid,
    output logic               o_pat_ready,
    sdd_out_if.source          o_out
);
    import sdd_pkg::*;

    logic             r_busy;
    logic [CNT_W-1:0] r_cnt;
    logic [PAT_W-1:0] r_sh;
    logic             r_en;

    logic             last;
    logic             xfer;
    logic             load;

    assign last        = (r_cnt == BIT_LAST);
    assign xfer        = r_busy && o_out.ready;
    assign o_pat_ready = !r_busy || (xfer && last);
    assign load        = i_pat_valid && o_pat_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_cnt  <= '0;
        end else if (load) begin
            r_busy <= 1'b1;
            r_cnt  <= '0;
        end else if (xfer) begin
            r_cnt <= r_cnt + 1'b1;
            if (last) begin
                r_busy <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (load) begin
            r_sh <= i_pat.pattern;
            r_en <= i_pat.display_enable;
        end else if (xfer) begin
            r_sh <= r_sh >> 1;
        end
    end

    assign o_out.valid               = r_busy;
    assign o_out.payload.serial_data = r_sh[0];
    assign o_out.payload.strobe_last = last;
    assign o_out.payload.panel_on    = last && r_en;

    `SDD_ASSERT(a_idle_cnt_zero, !r_busy |-> (r_cnt == '0),
        "bit counter not cleared when idle")
    `SDD_ASSERT_NEXT(a_stall_holds, r_busy && !o_out.ready,
        $stable(r_sh) && $stable(r_cnt) && r_busy, "serializer moved while stalled")
    `SDD_ASSERT_NEXT(a_done_idle, xfer && last && !i_pat_valid, !r_busy,
        "serializer stayed busy after last bit")
    `SDD_ASSERT_NEXT(a_reload, xfer && last && i_pat_valid, r_busy && (r_cnt == '0),
        "waiting pattern not loaded after last bit")

endmodule

[design/segment_display_serial_driver_core.sv]
// Top level of the segment display serial driver.
// Depends on sdd_pkg, sdd_if, sdd_encode and sdd_serializer.
//
// Usage: each transfer on i_in carries an operation (number or letter), an
// 8-bit value and a display enable level. The block turns it into a 16-bit
// segment pattern and sends that pattern on o_out as sixteen transfers, one
// pattern bit each, least significant bit first. The sixteenth transfer has
// strobe_last set and carries the display enable in panel_on; on the other
// fifteen both are 0.
// Path: an item passes through the input register, the pattern register and
// the serializer shift register before its first bit is offered on o_out.
// Throughput: the serializer shift register sends one bit per cycle while
// o_out.ready is high, and takes the next pattern as the last bit goes out.
// Two more items can be held in the input and pattern registers while a
// pattern is being shifted out, so i_in keeps accepting until those fill.
// Stalls: when o_out.ready is low the current bit holds, and the input side
// backs up only once both holding registers are full.
// Reset: i_rst_n is synchronous and active low; it drops every item in flight
// and leaves o_out.valid low with i_in.ready high.
module segment_display_serial_driver_core (
    input  logic      i_clk,
    input  logic      i_rst_n,
    sdd_in_if.sink    i_in,
    sdd_out_if.source o_out
);
    import sdd_pkg::*;

    t_pat_item pat;
    logic      pat_valid;
    logic      pat_ready;

    // Input register, saturation, digit split and table lookups.
    sdd_encode u_encode (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in        (i_in),
        .o_pat       (pat),
        .o_pat_valid (pat_valid),
        .i_pat_ready (pat_ready)
    );

    // Shift register that emits one pattern bit per output transfer.
    sdd_serializer u_serializer (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_pat       (pat),
        .i_pat_valid (pat_valid),
        .o_pat_ready (pat_ready),
        .o_out       (o_out)
    );

endmodule
